@@ hdl/qtc_pkg.sv @@
// qtc_pkg: shared types, constants and sizing functions for the quadtree leaf counter
// used by qtc_ctrl, qtc_datapath and quadtree_uniform_block_count
// depends on nothing
package qtc_pkg;

   // field widths
   localparam int SIDE_LOG2_W = 3;
   localparam int COUNT_W     = 15;
   localparam int CELL_W      = 2;

   // largest side_log2 the register can hold, its reset value and the default store side
   localparam int                     SIDE_LOG2_MAX = 7;
   localparam logic [SIDE_LOG2_W-1:0] SIDE_LOG2_RST = 3'd7;
   localparam int                     MAX_SIDE_DEF  = 128;

   // cell codes held in the store during the merge
   localparam logic [CELL_W-1:0] CELL_WHITE = 2'd0;
   localparam logic [CELL_W-1:0] CELL_BLUE  = 2'd1;
   localparam logic [CELL_W-1:0] CELL_MIXED = 2'd2;

   // controller states
   typedef enum logic [2:0] {
      ST_LOAD,
      ST_RD,
      ST_WR,
      ST_FIN_RD,
      ST_FIN_WAIT,
      ST_PUSH
   } qtc_state_type;

   // controller to datapath
   typedef struct packed {
      logic pix_wr;
      logic merge_start;
      logic rd_issue;
      logic node_write;
      logic level_next;
      logic fin_issue;
      logic fin_add;
      logic push;
   } qtc_cmd_type;

   // datapath to controller
   typedef struct packed {
      logic pix_last;
      logic side_one;
      logic q_last;
      logic level_last;
      logic last_level;
      logic out_free;
   } qtc_sts_type;

   // largest usable log2 of the side: bounded by the store and by the register
   function automatic int eff_max(input int max_side);
      int e;
      e = 0;
      while (e < SIDE_LOG2_MAX && (2 << e) <= max_side)
         e = e + 1;
      return e;
   endfunction

   // store address width, never below one bit
   function automatic int addr_w(input int max_side);
      int w;
      w = 2 * eff_max(max_side);
      return (w < 1) ? 1 : w;
   endfunction

endpackage

@@ hdl/qtc_ram.sv @@
// qtc_ram: generic single write port, single read port RAM with registered read data
// depends on nothing
module qtc_ram #(
   parameter int WIDTH = 2,
   parameter int DEPTH = 16384
) (
   input  logic                                      clock,
   input  logic                                      wr_en,
   input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] wr_addr,
   input  logic [WIDTH-1:0]                          wr_data,
   input  logic                                      rd_en,
   input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] rd_addr,
   output logic [WIDTH-1:0]                          rd_data
);

   logic [WIDTH-1:0] mem_ff [DEPTH];
   logic [WIDTH-1:0] rd_data_ff;

   // write port
   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem_ff[wr_addr] <= wr_data;
      end
   end

   // registered read port
   always_ff @(posedge clock) begin
      if (rd_en) begin
         rd_data_ff <= mem_ff[rd_addr];
      end
   end

   assign rd_data = rd_data_ff;

endmodule

@@ hdl/qtc_ctrl.sv @@
// qtc_ctrl: sequencer for load, bottom-up merge, root read and result push
// depends on qtc_pkg
module qtc_ctrl (
   input  logic                 clock,
   input  logic                 reset,
   input  logic                 req_valid,
   output logic                 req_ready,
   output qtc_pkg::qtc_cmd_type cmd,
   input  qtc_pkg::qtc_sts_type sts
);

   qtc_pkg::qtc_state_type state_ff;
   qtc_pkg::qtc_state_type state_in;

   // state register
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= qtc_pkg::ST_LOAD;
      end else begin
         state_ff <= state_in;
      end
   end

   // next state and commands
   always_comb begin
      state_in  = state_ff;
      cmd       = '0;
      req_ready = 1'b0;
      case (state_ff)
         qtc_pkg::ST_LOAD: begin
            req_ready = 1'b1;
            if (req_valid) begin
               cmd.pix_wr = 1'b1;
               if (sts.pix_last) begin
                  cmd.merge_start = 1'b1;
                  state_in = sts.side_one ? qtc_pkg::ST_FIN_RD : qtc_pkg::ST_RD;
               end
            end
         end
         qtc_pkg::ST_RD: begin
            // four reads per node, one per cycle
            cmd.rd_issue = 1'b1;
            if (sts.q_last) begin
               state_in = qtc_pkg::ST_WR;
            end
         end
         qtc_pkg::ST_WR: begin
            cmd.node_write = 1'b1;
            if (sts.level_last && sts.last_level) begin
               state_in = qtc_pkg::ST_FIN_RD;
            end else begin
               cmd.level_next = sts.level_last;
               state_in = qtc_pkg::ST_RD;
            end
         end
         qtc_pkg::ST_FIN_RD: begin
            cmd.fin_issue = 1'b1;
            state_in = qtc_pkg::ST_FIN_WAIT;
         end
         qtc_pkg::ST_FIN_WAIT: begin
            cmd.fin_add = 1'b1;
            state_in = qtc_pkg::ST_PUSH;
         end
         qtc_pkg::ST_PUSH: begin
            // wait for the output register to free up
            if (sts.out_free) begin
               cmd.push = 1'b1;
               state_in = qtc_pkg::ST_LOAD;
            end
         end
         default: begin
            state_in = qtc_pkg::ST_LOAD;
         end
      endcase
   end

endmodule

@@ hdl/qtc_datapath.sv @@
// qtc_datapath: pixel store, merge address generation, leaf counters and output register
// depends on qtc_pkg and qtc_ram
module qtc_datapath #(
   parameter int MAX_SIDE = qtc_pkg::MAX_SIDE_DEF
) (
   input  logic                               clock,
   input  logic                               reset,
   input  qtc_pkg::qtc_cmd_type               cmd,
   output qtc_pkg::qtc_sts_type               sts,
   input  logic                               req_pixel,
   input  logic                               csr_valid,
   input  logic [qtc_pkg::SIDE_LOG2_W-1:0]    csr_side_log2,
   input  logic                               rsp_ready,
   output logic                               rsp_valid,
   output logic [qtc_pkg::COUNT_W-1:0]        rsp_white_count,
   output logic [qtc_pkg::COUNT_W-1:0]        rsp_blue_count
);

   localparam int EFF_MAX = qtc_pkg::eff_max(MAX_SIDE);
   localparam int ADDR_W  = qtc_pkg::addr_w(MAX_SIDE);
   localparam int DEPTH   = 1 << (2 * EFF_MAX);
   localparam int SIDE_W  = EFF_MAX + 1;
   localparam logic [qtc_pkg::SIDE_LOG2_W-1:0] LOG2_CAP = qtc_pkg::SIDE_LOG2_W'(EFF_MAX);

   logic [qtc_pkg::SIDE_LOG2_W-1:0] side_log2_ff, side_log2_in;
   logic [ADDR_W-1:0]               pix_cnt_ff, pix_cnt_in;
   logic [SIDE_W-1:0]               n_ff, n_in;
   logic [SIDE_W-1:0]               x_ff, x_in;
   logic [ADDR_W-1:0]               nodes_m1_ff, nodes_m1_in;
   logic [ADDR_W-1:0]               wr_ptr_ff, wr_ptr_in;
   logic [ADDR_W-1:0]               base_ff, base_in;
   logic [1:0]                      q_idx_ff, q_idx_in;
   logic [qtc_pkg::CELL_W-1:0]      cap_ff [3];
   logic [qtc_pkg::COUNT_W-1:0]     white_ff, white_in;
   logic [qtc_pkg::COUNT_W-1:0]     blue_ff, blue_in;
   logic                            rsp_valid_ff, rsp_valid_in;
   logic [qtc_pkg::COUNT_W-1:0]     rsp_white_ff, rsp_blue_ff;

   logic [qtc_pkg::SIDE_LOG2_W-1:0] eff;
   logic [ADDR_W:0]                 tot_full;
   logic [ADDR_W-1:0]               tot_m1;
   logic [SIDE_W-1:0]               h_m1;
   logic                            x_last;
   logic                            ram_we, ram_re;
   logic [ADDR_W-1:0]               ram_waddr, ram_raddr, rd_off;
   logic [qtc_pkg::CELL_W-1:0]      ram_wdata, rd_data;
   logic                            uniform;
   logic [2:0]                      zeros, ones;

   // effective side and image size
   assign eff      = (side_log2_ff > LOG2_CAP) ? LOG2_CAP : side_log2_ff;
   assign tot_full = (ADDR_W + 1)'(1) << {eff, 1'b0};
   assign tot_m1   = ADDR_W'(tot_full - (ADDR_W + 1)'(1));
   assign h_m1     = (n_ff >> 1) - SIDE_W'(1);
   assign x_last   = (x_ff == h_m1);

   // status to the controller
   assign sts.pix_last   = (pix_cnt_ff == tot_m1);
   assign sts.side_one   = (eff == '0);
   assign sts.q_last     = (q_idx_ff == 2'd3);
   assign sts.level_last = (wr_ptr_ff == nodes_m1_ff);
   assign sts.last_level = (n_ff == SIDE_W'(2));
   assign sts.out_free   = !rsp_valid_ff || rsp_ready;

   // quadrant reads: base, base+1, base+n, base+n+1
   assign rd_off    = q_idx_ff[1] ? ADDR_W'(n_ff) : '0;
   assign ram_re    = cmd.rd_issue || cmd.fin_issue;
   assign ram_raddr = cmd.fin_issue ? '0 : (base_ff + rd_off + ADDR_W'(q_idx_ff[0]));

   // combine four cells: the fourth comes straight off the read port
   assign uniform = (cap_ff[0] == cap_ff[1]) && (cap_ff[1] == cap_ff[2]) &&
                    (cap_ff[2] == rd_data) && (rd_data != qtc_pkg::CELL_MIXED);
   assign zeros = {2'b00, cap_ff[0] == qtc_pkg::CELL_WHITE} +
                  {2'b00, cap_ff[1] == qtc_pkg::CELL_WHITE} +
                  {2'b00, cap_ff[2] == qtc_pkg::CELL_WHITE} +
                  {2'b00, rd_data == qtc_pkg::CELL_WHITE};
   assign ones  = {2'b00, cap_ff[0] == qtc_pkg::CELL_BLUE} +
                  {2'b00, cap_ff[1] == qtc_pkg::CELL_BLUE} +
                  {2'b00, cap_ff[2] == qtc_pkg::CELL_BLUE} +
                  {2'b00, rd_data == qtc_pkg::CELL_BLUE};

   // store write: incoming pixels, then merged nodes in place
   assign ram_we    = cmd.pix_wr || cmd.node_write;
   assign ram_waddr = cmd.pix_wr ? pix_cnt_ff : wr_ptr_ff;
   assign ram_wdata = cmd.pix_wr ? {1'b0, req_pixel} :
                      (uniform ? rd_data : qtc_pkg::CELL_MIXED);

   qtc_ram #(
      .WIDTH (qtc_pkg::CELL_W),
      .DEPTH (DEPTH)
   ) u_store (
      .clock   (clock),
      .wr_en   (ram_we),
      .wr_addr (ram_waddr),
      .wr_data (ram_wdata),
      .rd_en   (ram_re),
      .rd_addr (ram_raddr),
      .rd_data (rd_data)
   );

   // configuration and pixel counter
   always_comb begin
      side_log2_in = side_log2_ff;
      pix_cnt_in   = pix_cnt_ff;
      if (csr_valid) begin
         side_log2_in = csr_side_log2;
         pix_cnt_in   = '0;
      end else if (cmd.pix_wr) begin
         pix_cnt_in = sts.pix_last ? '0 : (pix_cnt_ff + ADDR_W'(1));
      end
   end

   // merge walk: node base, column, write pointer, level size
   always_comb begin
      n_in        = n_ff;
      x_in        = x_ff;
      nodes_m1_in = nodes_m1_ff;
      wr_ptr_in   = wr_ptr_ff;
      base_in     = base_ff;
      q_idx_in    = q_idx_ff;
      if (cmd.rd_issue) begin
         q_idx_in = q_idx_ff + 2'd1;
      end
      if (cmd.merge_start || cmd.level_next) begin
         x_in      = '0;
         wr_ptr_in = '0;
         base_in   = '0;
         q_idx_in  = '0;
         if (cmd.merge_start) begin
            n_in        = SIDE_W'(1) << eff;
            nodes_m1_in = ADDR_W'((tot_full >> 2) - (ADDR_W + 1)'(1));
         end else begin
            n_in        = n_ff >> 1;
            nodes_m1_in = nodes_m1_ff >> 2;
         end
      end else if (cmd.node_write) begin
         wr_ptr_in = wr_ptr_ff + ADDR_W'(1);
         if (x_last) begin
            // skip the odd row of the current level
            x_in    = '0;
            base_in = base_ff + ADDR_W'(n_ff) + ADDR_W'(2);
         end else begin
            x_in    = x_ff + SIDE_W'(1);
            base_in = base_ff + ADDR_W'(2);
         end
      end
   end

   // leaf totals
   always_comb begin
      white_in = white_ff;
      blue_in  = blue_ff;
      if (cmd.merge_start) begin
         white_in = '0;
         blue_in  = '0;
      end else if (cmd.node_write && !uniform) begin
         white_in = white_ff + qtc_pkg::COUNT_W'(zeros);
         blue_in  = blue_ff + qtc_pkg::COUNT_W'(ones);
      end else if (cmd.fin_add) begin
         white_in = white_ff + qtc_pkg::COUNT_W'(rd_data == qtc_pkg::CELL_WHITE);
         blue_in  = blue_ff + qtc_pkg::COUNT_W'(rd_data == qtc_pkg::CELL_BLUE);
      end
   end

   // output register valid
   always_comb begin
      rsp_valid_in = rsp_valid_ff;
      if (cmd.push) begin
         rsp_valid_in = 1'b1;
      end else if (rsp_ready) begin
         rsp_valid_in = 1'b0;
      end
   end

   // control registers
   always_ff @(posedge clock) begin
      if (reset) begin
         side_log2_ff <= qtc_pkg::SIDE_LOG2_RST;
         pix_cnt_ff   <= '0;
         q_idx_ff     <= '0;
         white_ff     <= '0;
         blue_ff      <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         side_log2_ff <= side_log2_in;
         pix_cnt_ff   <= pix_cnt_in;
         q_idx_ff     <= q_idx_in;
         white_ff     <= white_in;
         blue_ff      <= blue_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   // walk registers, captured cells and result payload
   always_ff @(posedge clock) begin
      n_ff        <= n_in;
      x_ff        <= x_in;
      nodes_m1_ff <= nodes_m1_in;
      wr_ptr_ff   <= wr_ptr_in;
      base_ff     <= base_in;
      if (cmd.rd_issue && (q_idx_ff != 2'd0)) begin
         cap_ff[0] <= cap_ff[1];
         cap_ff[1] <= cap_ff[2];
         cap_ff[2] <= rd_data;
      end
      if (cmd.push) begin
         rsp_white_ff <= white_ff;
         rsp_blue_ff  <= blue_ff;
      end
   end

   assign rsp_valid       = rsp_valid_ff;
   assign rsp_white_count = rsp_white_ff;
   assign rsp_blue_count  = rsp_blue_ff;

   // a result is never loaded over one still waiting
   ap_push_free: assert property (@(posedge clock) disable iff (reset)
      cmd.push |-> (!rsp_valid_ff || rsp_ready))
      else $error("result pushed over a pending item");

   // each node write closes a group of four reads
   ap_quad_wrap: assert property (@(posedge clock) disable iff (reset)
      cmd.node_write |-> (q_idx_ff == 2'd0) && $past(cmd.rd_issue))
      else $error("node written without four quadrant reads");

   // pixel loading and the merge never share the write port
   ap_one_writer: assert property (@(posedge clock) disable iff (reset)
      !(cmd.pix_wr && (cmd.node_write || cmd.rd_issue)))
      else $error("pixel write during merge");

endmodule

@@ hdl/quadtree_uniform_block_count.sv @@
// quadtree_uniform_block_count: top level of the quadtree leaf counter
// depends on qtc_pkg, qtc_ctrl and qtc_datapath (which holds qtc_ram)
//
//   channel   ports                                      direction
//   req       req_valid, req_ready, req_pixel            in   one pixel per item, raster order
//   rsp       rsp_valid, rsp_ready, rsp_white_count,     out  one item per image
//             rsp_blue_count
//   csr       csr_valid, csr_ready, csr_side_log2        in   side_log2, clears the pixel count
//
// pixels are taken one per cycle; the last pixel of an image starts the merge
// merge: each node takes four reads on the single store read port, then one write;
// the root is then read and counted, and the result pushed to the output register
// req_ready is low from the last pixel until the result is in the output register
// a waiting result does not stop loading of the next image
// reset is synchronous; side_log2 resets to 7, the store needs no clearing
module quadtree_uniform_block_count #(
   parameter int MAX_SIDE = qtc_pkg::MAX_SIDE_DEF
) (
   input  logic                            clock,
   input  logic                            reset,
   input  logic                            req_valid,
   output logic                            req_ready,
   input  logic                            req_pixel,
   output logic                            rsp_valid,
   input  logic                            rsp_ready,
   output logic [qtc_pkg::COUNT_W-1:0]     rsp_white_count,
   output logic [qtc_pkg::COUNT_W-1:0]     rsp_blue_count,
   input  logic                            csr_valid,
   output logic                            csr_ready,
   input  logic [qtc_pkg::SIDE_LOG2_W-1:0] csr_side_log2
);

   qtc_pkg::qtc_cmd_type cmd;
   qtc_pkg::qtc_sts_type sts;

   // register writes are always taken
   assign csr_ready = 1'b1;

   qtc_ctrl u_ctrl (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .req_ready (req_ready),
      .cmd       (cmd),
      .sts       (sts)
   );

   qtc_datapath #(
      .MAX_SIDE (MAX_SIDE)
   ) u_datapath (
      .clock           (clock),
      .reset           (reset),
      .cmd             (cmd),
      .sts             (sts),
      .req_pixel       (req_pixel),
      .csr_valid       (csr_valid),
      .csr_side_log2   (csr_side_log2),
      .rsp_ready       (rsp_ready),
      .rsp_valid       (rsp_valid),
      .rsp_white_count (rsp_white_count),
      .rsp_blue_count  (rsp_blue_count)
   );

endmodule
